FILE: rtl/chmt_pkg.sv
// Shared types and constants of the cache hit/miss tracker.
// No dependencies; used by every other file of the block.
package chmt_pkg;

    // Configuration register indexes (byte address = 4 * index)
    localparam logic [1:0] REG_LINE_SIZE_LOG2   = 2'd0;
    localparam logic [1:0] REG_CACHE_LINES_LOG2 = 2'd1;
    localparam logic [1:0] REG_SET_WAYS_LOG2    = 2'd2;

    localparam logic [3:0] LINE_LOG2_CAP = 4'd12;

    localparam logic [3:0] RST_LINE_SIZE_LOG2   = 4'd2;
    localparam logic [3:0] RST_CACHE_LINES_LOG2 = 4'd8;
    localparam logic [3:0] RST_SET_WAYS_LOG2    = 4'd2;

    // Hit flag positions
    localparam int H_DIR   = 0;
    localparam int H_FFIFO = 1;
    localparam int H_FLRU  = 2;
    localparam int H_SFIFO = 3;
    localparam int H_SLRU  = 4;

    typedef struct packed {
        logic [3:0] line_size_log2;
        logic [3:0] cache_lines_log2;
        logic [3:0] set_ways_log2;
    } cfg_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PREP,
        ST_SCAN,
        ST_DRAIN,
        ST_UPDATE
    } state_t;

    // Controller to datapath
    typedef struct packed {
        logic idle;
        logic accept;
        logic start;
        logic scan;
        logic update;
    } cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic scan_last;
        logic out_busy;
    } status_t;

endpackage

FILE: rtl/chmt_ctrl.sv
// Sequencer of the tracker: accept, prepare, scan the tag stores, update.
// Depends on chmt_pkg.
module chmt_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    input  chmt_pkg::status_t  status,
    output chmt_pkg::cmd_t     cmd
);

    chmt_pkg::state_t state_reg, state_next;

    // State register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= chmt_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            chmt_pkg::ST_IDLE: begin
                if (s_valid) state_next = chmt_pkg::ST_PREP;
            end
            chmt_pkg::ST_PREP:  state_next = chmt_pkg::ST_SCAN;
            chmt_pkg::ST_SCAN: begin
                if (status.scan_last) state_next = chmt_pkg::ST_DRAIN;
            end
            chmt_pkg::ST_DRAIN: state_next = chmt_pkg::ST_UPDATE;
            chmt_pkg::ST_UPDATE: begin
                if (!status.out_busy) state_next = chmt_pkg::ST_IDLE;
            end
            default: state_next = chmt_pkg::ST_IDLE;
        endcase
    end

    // Commands
    always_comb begin
        cmd = '0;
        unique case (state_reg)
            chmt_pkg::ST_IDLE: begin
                cmd.idle   = 1'b1;
                cmd.accept = s_valid;
            end
            chmt_pkg::ST_PREP:   cmd.start  = 1'b1;
            chmt_pkg::ST_SCAN:   cmd.scan   = 1'b1;
            chmt_pkg::ST_DRAIN:  cmd = '0;
            chmt_pkg::ST_UPDATE: cmd.update = !status.out_busy;
            default: cmd = '0;
        endcase
    end

endmodule

FILE: rtl/chmt_datapath.sv
// Tag stores, valid bits, lookup trackers, fill pointers and counters.
// Depends on chmt_pkg; driven by chmt_ctrl commands.
module chmt_datapath #(
    parameter int MAX_LINES  = 256,
    parameter int ADDR_BITS  = 32,
    parameter int STAMP_BITS = 32
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  chmt_pkg::cfg_t     cfg,
    input  logic               cfg_wr,
    input  chmt_pkg::cmd_t     cmd,
    output chmt_pkg::status_t  status,
    input  logic [31:0]        s_address,
    input  logic               m_ready,
    output logic               m_valid,
    output logic [4:0]         hit_flags,
    output logic [31:0]        access_total,
    output logic [31:0]        hit_count [5]
);

    localparam int IDX_W = (MAX_LINES > 1) ? $clog2(MAX_LINES) : 1;
    localparam int CAP   = $clog2(MAX_LINES + 1) - 1;

    // Effective geometry
    logic [3:0]           lsz, cl, w;
    logic [IDX_W-1:0]     lmask, smask, wmask;
    logic [ADDR_BITS-1:0] addr_reg, blk;
    logic [IDX_W-1:0]     k, set_i, base;

    always_comb begin
        lsz   = (cfg.line_size_log2 > chmt_pkg::LINE_LOG2_CAP) ?
                chmt_pkg::LINE_LOG2_CAP : cfg.line_size_log2;
        cl    = (cfg.cache_lines_log2 > 4'(CAP)) ? 4'(CAP) : cfg.cache_lines_log2;
        w     = (cfg.set_ways_log2 > cl) ? cl : cfg.set_ways_log2;
        lmask = ~({IDX_W{1'b1}} << cl);
        wmask = ~({IDX_W{1'b1}} << w);
        smask = lmask >> w;
        blk   = addr_reg >> lsz;
        k     = blk[IDX_W-1:0] & lmask;
        set_i = blk[IDX_W-1:0] & smask;
        base  = set_i << w;
    end

    // Address capture, masked or widened to ADDR_BITS
    logic [ADDR_BITS+31:0] addr_wide;
    assign addr_wide = {{ADDR_BITS{1'b0}}, s_address};

    always_ff @(posedge aclk) begin
        if (cmd.accept) addr_reg <= addr_wide[ADDR_BITS-1:0];
    end

    // Scan counter and read pipeline flag
    logic [IDX_W-1:0] cnt_reg, idx_d_reg;
    logic             rd_vld_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rd_vld_reg <= 1'b0;
        end else begin
            rd_vld_reg <= cmd.scan;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.start) begin
            cnt_reg <= '0;
        end else if (cmd.scan) begin
            cnt_reg <= cnt_reg + 1'b1;
        end
        if (cmd.scan) idx_d_reg <= cnt_reg;
    end

    assign status.scan_last = (cnt_reg == lmask);

    // Memories
    logic [ADDR_BITS-1:0]  dir_mem   [MAX_LINES];
    logic [ADDR_BITS-1:0]  ffifo_mem [MAX_LINES];
    logic [ADDR_BITS-1:0]  flru_mem  [MAX_LINES];
    logic [ADDR_BITS-1:0]  sfifo_mem [MAX_LINES];
    logic [ADDR_BITS-1:0]  slru_mem  [MAX_LINES];
    logic [STAMP_BITS-1:0] flru_stm  [MAX_LINES];
    logic [STAMP_BITS-1:0] slru_stm  [MAX_LINES];
    logic [IDX_W-1:0]      sfill_mem [MAX_LINES];

    logic [ADDR_BITS-1:0]  dir_q, ffifo_q, flru_q, sfifo_q, slru_q;
    logic [STAMP_BITS-1:0] flru_sq, slru_sq;
    logic [IDX_W-1:0]      sfill_q;

    // Valid bits
    logic [MAX_LINES-1:0] dir_vld_reg, ffifo_vld_reg, flru_vld_reg;
    logic [MAX_LINES-1:0] sfifo_vld_reg, slru_vld_reg, sfill_vld_reg;
    logic [IDX_W-1:0]     ffill_reg;

    // Registered reads
    always_ff @(posedge aclk) begin
        if (cmd.scan) begin
            dir_q   <= dir_mem[cnt_reg];
            ffifo_q <= ffifo_mem[cnt_reg];
            flru_q  <= flru_mem[cnt_reg];
            sfifo_q <= sfifo_mem[cnt_reg];
            slru_q  <= slru_mem[cnt_reg];
            flru_sq <= flru_stm[cnt_reg];
            slru_sq <= slru_stm[cnt_reg];
        end
        if (cmd.start) sfill_q <= sfill_mem[set_i];
    end

    // Compare trackers
    logic             dh_reg, ffh_reg, sfh_reg;
    logic             fh_reg, finv_reg, fmin_reg;
    logic [IDX_W-1:0] fh_i_reg, finv_i_reg, fmin_i_reg;
    logic [STAMP_BITS-1:0] fmin_s_reg;
    logic             sh_reg, sinv_reg, smin_reg;
    logic [IDX_W-1:0] sh_i_reg, sinv_i_reg, smin_i_reg;
    logic [STAMP_BITS-1:0] smin_s_reg;

    logic in_set;
    assign in_set = ((idx_d_reg >> w) == set_i);

    always_ff @(posedge aclk) begin
        if (cmd.start) begin
            dh_reg   <= 1'b0;
            ffh_reg  <= 1'b0;
            sfh_reg  <= 1'b0;
            fh_reg   <= 1'b0;
            finv_reg <= 1'b0;
            fmin_reg <= 1'b0;
            sh_reg   <= 1'b0;
            sinv_reg <= 1'b0;
            smin_reg <= 1'b0;
        end else if (rd_vld_reg) begin
            if (idx_d_reg == k && dir_vld_reg[idx_d_reg] && dir_q == blk) dh_reg <= 1'b1;
            if (ffifo_vld_reg[idx_d_reg] && ffifo_q == blk) ffh_reg <= 1'b1;
            // fully associative LRU
            if (flru_vld_reg[idx_d_reg]) begin
                if (flru_q == blk && !fh_reg) begin
                    fh_reg   <= 1'b1;
                    fh_i_reg <= idx_d_reg;
                end
                if (!fmin_reg || flru_sq < fmin_s_reg) begin
                    fmin_reg   <= 1'b1;
                    fmin_i_reg <= idx_d_reg;
                    fmin_s_reg <= flru_sq;
                end
            end else if (!finv_reg) begin
                finv_reg   <= 1'b1;
                finv_i_reg <= idx_d_reg;
            end
            // set associative, only ways of the selected set
            if (in_set) begin
                if (sfifo_vld_reg[idx_d_reg] && sfifo_q == blk) sfh_reg <= 1'b1;
                if (slru_vld_reg[idx_d_reg]) begin
                    if (slru_q == blk && !sh_reg) begin
                        sh_reg   <= 1'b1;
                        sh_i_reg <= idx_d_reg;
                    end
                    if (!smin_reg || slru_sq < smin_s_reg) begin
                        smin_reg   <= 1'b1;
                        smin_i_reg <= idx_d_reg;
                        smin_s_reg <= slru_sq;
                    end
                end else if (!sinv_reg) begin
                    sinv_reg   <= 1'b1;
                    sinv_i_reg <= idx_d_reg;
                end
            end
        end
    end

    // Counters and stamp of this access
    logic [31:0] acc_reg, acc_next;
    logic [31:0] hc_reg [5];
    logic [STAMP_BITS+31:0] now_wide;
    logic [STAMP_BITS-1:0]  now;
    logic [4:0]  hits;

    assign acc_next = (acc_reg == 32'hFFFF_FFFF) ? acc_reg : acc_reg + 32'd1;
    assign now_wide = {{STAMP_BITS{1'b0}}, acc_next};
    assign now = (now_wide > {{32{1'b0}}, {STAMP_BITS{1'b1}}}) ?
                 {STAMP_BITS{1'b1}} : now_wide[STAMP_BITS-1:0];
    assign hits = {sh_reg, sfh_reg, fh_reg, ffh_reg, dh_reg};

    // Victim selection
    logic [IDX_W-1:0] fvic, svic, fslot, sslot, sfill_cur, faddr, saddr;
    always_comb begin
        fvic      = finv_reg ? finv_i_reg : fmin_i_reg;
        svic      = sinv_reg ? sinv_i_reg : smin_i_reg;
        fslot     = ffill_reg & lmask;
        sfill_cur = sfill_vld_reg[set_i] ? sfill_q : '0;
        sslot     = sfill_cur & wmask;
        faddr     = fh_reg ? fh_i_reg : fvic;
        saddr     = sh_reg ? sh_i_reg : svic;
    end

    // Memory writes
    always_ff @(posedge aclk) begin
        if (cmd.update) begin
            if (!dh_reg)  dir_mem[k] <= blk;
            if (!ffh_reg) ffifo_mem[fslot] <= blk;
            if (!fh_reg)  flru_mem[fvic] <= blk;
            flru_stm[faddr] <= now;
            if (!sfh_reg) begin
                sfifo_mem[base | sslot] <= blk;
                sfill_mem[set_i] <= (sslot + 1'b1) & wmask;
            end
            if (!sh_reg)  slru_mem[svic] <= blk;
            slru_stm[saddr] <= now;
        end
    end

    // Valid bits and fully associative fill pointer
    always_ff @(posedge aclk) begin
        if (!aresetn || cfg_wr) begin
            dir_vld_reg   <= '0;
            ffifo_vld_reg <= '0;
            flru_vld_reg  <= '0;
            sfifo_vld_reg <= '0;
            slru_vld_reg  <= '0;
            sfill_vld_reg <= '0;
            ffill_reg     <= '0;
        end else if (cmd.update) begin
            if (!dh_reg) dir_vld_reg[k] <= 1'b1;
            if (!ffh_reg) begin
                ffifo_vld_reg[fslot] <= 1'b1;
                ffill_reg <= (fslot + 1'b1) & lmask;
            end
            if (!fh_reg) flru_vld_reg[fvic] <= 1'b1;
            if (!sfh_reg) begin
                sfifo_vld_reg[base | sslot] <= 1'b1;
                sfill_vld_reg[set_i] <= 1'b1;
            end
            if (!sh_reg) slru_vld_reg[svic] <= 1'b1;
        end
    end

    // Counters, hit flags and result beat
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acc_reg   <= '0;
            for (int i = 0; i < 5; i++) hc_reg[i] <= '0;
            hit_flags <= '0;
            m_valid   <= 1'b0;
        end else if (cmd.update) begin
            acc_reg   <= acc_next;
            for (int i = 0; i < 5; i++) begin
                if (hits[i] && hc_reg[i] != 32'hFFFF_FFFF) hc_reg[i] <= hc_reg[i] + 32'd1;
            end
            hit_flags <= hits;
            m_valid   <= 1'b1;
        end else if (m_ready) begin
            m_valid   <= 1'b0;
        end
    end

    assign status.out_busy = m_valid && !m_ready;
    assign access_total    = acc_reg;
    assign hit_count       = hc_reg;

endmodule

FILE: rtl/cache_hit_miss_tracker_unit.sv
// Top level of the cache hit/miss tracker: APB registers, controller, datapath.
// Depends on chmt_pkg, chmt_ctrl and chmt_datapath.
//
//  channel | direction | handshake          | payload
//  s_      | in        | s_valid / s_ready  | s_address
//  m_      | out       | m_valid / m_ready  | five hit flags, total, five hit counts
//  apb     | in        | psel/penable/pready| three 4-bit geometry registers
//
// An item passes through accept, prepare, a walk of the tag memories one entry a cycle
// through their single read port, a drain state for the last read, then an update.
// The update waits while the previous result beat is still unread.
// Reset clears all valid bits, fill pointers and counters at once; no clearing pass.
// Any register write invalidates the stores; counters are kept.
module cache_hit_miss_tracker_unit #(
    parameter int MAX_LINES  = 256,
    parameter int ADDR_BITS  = 32,
    parameter int STAMP_BITS = 32
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [31:0] s_address,
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_direct_hit,
    output logic        m_full_fifo_hit,
    output logic        m_full_lru_hit,
    output logic        m_set_fifo_hit,
    output logic        m_set_lru_hit,
    output logic [31:0] m_access_total,
    output logic [31:0] m_direct_hits,
    output logic [31:0] m_full_fifo_hits,
    output logic [31:0] m_full_lru_hits,
    output logic [31:0] m_set_fifo_hits,
    output logic [31:0] m_set_lru_hits
);

    chmt_pkg::cfg_t    cfg_reg;
    chmt_pkg::cmd_t    cmd;
    chmt_pkg::status_t status;
    logic              cfg_wr;
    logic [4:0]        hit_flags;
    logic [31:0]       hit_count [5];

    // Register writes
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr[3:2] != 2'd3);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.line_size_log2   <= chmt_pkg::RST_LINE_SIZE_LOG2;
            cfg_reg.cache_lines_log2 <= chmt_pkg::RST_CACHE_LINES_LOG2;
            cfg_reg.set_ways_log2    <= chmt_pkg::RST_SET_WAYS_LOG2;
        end else if (cfg_wr) begin
            unique case (paddr[3:2])
                chmt_pkg::REG_LINE_SIZE_LOG2:   cfg_reg.line_size_log2   <= pwdata[3:0];
                chmt_pkg::REG_CACHE_LINES_LOG2: cfg_reg.cache_lines_log2 <= pwdata[3:0];
                chmt_pkg::REG_SET_WAYS_LOG2:    cfg_reg.set_ways_log2    <= pwdata[3:0];
                default: ;
            endcase
        end
    end

    // Register reads
    always_comb begin
        unique case (paddr[3:2])
            chmt_pkg::REG_LINE_SIZE_LOG2:   prdata = {28'd0, cfg_reg.line_size_log2};
            chmt_pkg::REG_CACHE_LINES_LOG2: prdata = {28'd0, cfg_reg.cache_lines_log2};
            chmt_pkg::REG_SET_WAYS_LOG2:    prdata = {28'd0, cfg_reg.set_ways_log2};
            default:                        prdata = 32'd0;
        endcase
    end

    chmt_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .status  (status),
        .cmd     (cmd)
    );

    chmt_datapath #(
        .MAX_LINES  (MAX_LINES),
        .ADDR_BITS  (ADDR_BITS),
        .STAMP_BITS (STAMP_BITS)
    ) u_dp (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg          (cfg_reg),
        .cfg_wr       (cfg_wr),
        .cmd          (cmd),
        .status       (status),
        .s_address    (s_address),
        .m_ready      (m_ready),
        .m_valid      (m_valid),
        .hit_flags    (hit_flags),
        .access_total (m_access_total),
        .hit_count    (hit_count)
    );

    assign s_ready          = cmd.idle;
    assign m_direct_hit     = hit_flags[chmt_pkg::H_DIR];
    assign m_full_fifo_hit  = hit_flags[chmt_pkg::H_FFIFO];
    assign m_full_lru_hit   = hit_flags[chmt_pkg::H_FLRU];
    assign m_set_fifo_hit   = hit_flags[chmt_pkg::H_SFIFO];
    assign m_set_lru_hit    = hit_flags[chmt_pkg::H_SLRU];
    assign m_direct_hits    = hit_count[chmt_pkg::H_DIR];
    assign m_full_fifo_hits = hit_count[chmt_pkg::H_FFIFO];
    assign m_full_lru_hits  = hit_count[chmt_pkg::H_FLRU];
    assign m_set_fifo_hits  = hit_count[chmt_pkg::H_SFIFO];
    assign m_set_lru_hits   = hit_count[chmt_pkg::H_SLRU];

endmodule

FILE: sim/tb_top.sv
// Testbench for the cache hit/miss tracker: drives address beats, predicts the five
// cache outcomes and running counts, and checks every result beat. Needs chmt_pkg and
// cache_hit_miss_tracker_unit only.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NLINES = 256;

    typedef struct {
        logic [4:0]  hits;
        logic [31:0] total;
        logic [31:0] counts [5];
    } outcome_t;

    logic        aclk;
    logic        aresetn;
    logic        psel, penable, pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    logic        s_valid, s_ready;
    logic [31:0] s_address;
    logic        m_valid, m_ready;
    logic        m_direct_hit, m_full_fifo_hit, m_full_lru_hit, m_set_fifo_hit, m_set_lru_hit;
    logic [31:0] m_access_total, m_direct_hits, m_full_fifo_hits, m_full_lru_hits;
    logic [31:0] m_set_fifo_hits, m_set_lru_hits;

    cache_hit_miss_tracker_unit u_top (.*);

    // Predictor state
    logic [3:0]  geo_line, geo_lines, geo_ways;
    logic        dir_v  [NLINES]; logic [31:0] dir_b  [NLINES];
    logic        ffv    [NLINES]; logic [31:0] ffb    [NLINES]; int unsigned ff_ptr;
    logic        flv    [NLINES]; logic [31:0] flb    [NLINES]; logic [31:0] fl_age [NLINES];
    logic        sfv    [NLINES]; logic [31:0] sfb    [NLINES]; int unsigned sf_ptr [NLINES];
    logic        slv    [NLINES]; logic [31:0] slb    [NLINES]; logic [31:0] sl_age [NLINES];
    logic [31:0] seen_total;
    logic [31:0] hit_tally [5];

    logic [31:0] address_q [$];
    outcome_t    outcome_q [$];
    int          errors;
    int          idle_cycles;
    logic        sender_hold;     // sender idles while set
    logic        quiet_run;       // no idling in the final part
    int          long_stall;      // receiver hold-off counter

    function automatic logic [31:0] sat_up(logic [31:0] v);
        return (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
    endfunction

    function automatic void flush_caches();
        for (int i = 0; i < NLINES; i++) begin
            dir_v[i] = 0; ffv[i] = 0; flv[i] = 0; sfv[i] = 0; slv[i] = 0;
            dir_b[i] = 0; ffb[i] = 0; flb[i] = 0; sfb[i] = 0; slb[i] = 0;
            fl_age[i] = 0; sl_age[i] = 0; sf_ptr[i] = 0;
        end
        ff_ptr = 0;
    endfunction

    function automatic logic fifo_lookup(ref logic v[NLINES], ref logic [31:0] b[NLINES],
                                         input int base, input int ways,
                                         ref int unsigned ptr, input logic [31:0] blk);
        int slot;
        for (int i = 0; i < ways; i++)
            if (v[base+i] && b[base+i] == blk) return 1'b1;
        slot = ptr & (ways - 1);
        v[base+slot] = 1'b1;
        b[base+slot] = blk;
        ptr = (slot + 1) & (ways - 1);
        return 1'b0;
    endfunction

    function automatic logic lru_lookup(ref logic v[NLINES], ref logic [31:0] b[NLINES],
                                        ref logic [31:0] age[NLINES], input int base,
                                        input int ways, input logic [31:0] blk,
                                        input logic [31:0] now);
        int victim;
        logic got_free;
        victim = base;
        got_free = 0;
        for (int i = 0; i < ways; i++)
            if (v[base+i] && b[base+i] == blk) begin
                age[base+i] = now;
                return 1'b1;
            end
        for (int i = 0; i < ways; i++)
            if (!got_free && !v[base+i]) begin
                victim = base + i;
                got_free = 1;
            end
        if (!got_free)
            for (int i = 0; i < ways; i++)
                if (age[base+i] < age[victim]) victim = base + i;
        v[victim] = 1'b1;
        b[victim] = blk;
        age[victim] = now;
        return 1'b0;
    endfunction

    // Work out the outcome of one access and advance the cache images
    function automatic outcome_t predict_access(logic [31:0] addr);
        outcome_t o;
        int lsz, cl, w, lines, ways, sets, k, set_idx, base;
        logic [31:0] blk;
        lsz = (geo_line > 12) ? 12 : geo_line;
        cl  = (geo_lines > 8) ? 8 : geo_lines;
        w   = (geo_ways > cl) ? cl : geo_ways;
        lines = 1 << cl;
        ways  = 1 << w;
        sets  = lines >> w;
        blk = addr >> lsz;
        seen_total = sat_up(seen_total);
        k = blk & (lines - 1);
        o.hits[chmt_pkg::H_DIR] = dir_v[k] && dir_b[k] == blk;
        if (!o.hits[chmt_pkg::H_DIR]) begin
            dir_v[k] = 1'b1;
            dir_b[k] = blk;
        end
        o.hits[chmt_pkg::H_FFIFO] = fifo_lookup(ffv, ffb, 0, lines, ff_ptr, blk);
        o.hits[chmt_pkg::H_FLRU]  = lru_lookup(flv, flb, fl_age, 0, lines, blk, seen_total);
        set_idx = blk & (sets - 1);
        base = set_idx << w;
        o.hits[chmt_pkg::H_SFIFO] = fifo_lookup(sfv, sfb, base, ways, sf_ptr[set_idx], blk);
        o.hits[chmt_pkg::H_SLRU]  = lru_lookup(slv, slb, sl_age, base, ways, blk, seen_total);
        for (int i = 0; i < 5; i++) begin
            if (o.hits[i]) hit_tally[i] = sat_up(hit_tally[i]);
            o.counts[i] = hit_tally[i];
        end
        o.total = seen_total;
        return o;
    endfunction

    // Clock
    initial begin
        aclk = 0;
        forever #10 aclk = ~aclk;
    end

    // Driver: offers queued addresses, holds valid until accepted
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 0;
            idle_cycles <= 0;
        end else if (!s_valid || s_ready) begin
            if (s_valid && s_ready)
                outcome_q.push_back(predict_access(s_address));
            if (idle_cycles > 0) begin
                idle_cycles <= idle_cycles - 1;
                s_valid <= 0;
            end else if (sender_hold || address_q.size() == 0) begin
                s_valid <= 0;
            end else if (!quiet_run && $urandom_range(0, 9) == 0) begin
                idle_cycles <= $urandom_range(1, 19) - 1;
                s_valid <= 0;
            end else begin
                s_valid <= 1;
                s_address <= address_q.pop_front();
            end
        end
    end

    // Monitor: receiver stalls and result checking
    int rx_idle;
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 0;
            rx_idle <= 0;
        end else begin
            if (m_valid && m_ready) begin
                if (outcome_q.size() == 0) begin
                    errors++;
                    if (errors <= 10) $display("unexpected result beat, total %0d", m_access_total);
                end else begin
                    outcome_t e;
                    e = outcome_q.pop_front();
                    if ({m_set_lru_hit, m_set_fifo_hit, m_full_lru_hit, m_full_fifo_hit,
                         m_direct_hit} !== e.hits || m_access_total !== e.total
                        || m_direct_hits !== e.counts[chmt_pkg::H_DIR]
                        || m_full_fifo_hits !== e.counts[chmt_pkg::H_FFIFO]
                        || m_full_lru_hits !== e.counts[chmt_pkg::H_FLRU]
                        || m_set_fifo_hits !== e.counts[chmt_pkg::H_SFIFO]
                        || m_set_lru_hits !== e.counts[chmt_pkg::H_SLRU]) begin
                        errors++;
                        if (errors <= 10) begin
                            $write("mismatch exp hits %b tot %0d cnt %0d %0d %0d %0d %0d",
                                e.hits, e.total, e.counts[0], e.counts[1], e.counts[2],
                                e.counts[3], e.counts[4]);
                            $display(" | got %b%b%b%b%b tot %0d cnt %0d %0d %0d %0d %0d",
                                m_set_lru_hit, m_set_fifo_hit,
                                m_full_lru_hit, m_full_fifo_hit, m_direct_hit, m_access_total,
                                m_direct_hits, m_full_fifo_hits, m_full_lru_hits,
                                m_set_fifo_hits, m_set_lru_hits);
                        end
                    end
                end
            end
            if (long_stall > 0) begin
                long_stall <= long_stall - 1;
                m_ready <= 0;
            end else if (rx_idle > 0) begin
                rx_idle <= rx_idle - 1;
                m_ready <= 0;
            end else if (!quiet_run && $urandom_range(0, 9) == 0) begin
                rx_idle <= $urandom_range(1, 19) - 1;
                m_ready <= 0;
            end else begin
                m_ready <= 1;
            end
        end
    end

    // Watchdog: cycles without any accepted beat
    int stuck;
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) stuck <= 0;
        else stuck <= stuck + 1;
        if (stuck > 20000) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    task automatic apb_write(logic [1:0] idx, logic [3:0] val);
        @(posedge aclk);
        psel <= 1; penable <= 0; pwrite <= 1; paddr <= {idx, 2'b00}; pwdata <= {28'd0, val};
        @(posedge aclk);
        penable <= 1;
        @(posedge aclk);
        psel <= 0; penable <= 0; pwrite <= 0;
        case (idx)
            chmt_pkg::REG_LINE_SIZE_LOG2:   geo_line  = val;
            chmt_pkg::REG_CACHE_LINES_LOG2: geo_lines = val;
            default:                        geo_ways  = val;
        endcase
        flush_caches();
    endtask

    // Wait until all queued addresses are sent and every result is back
    task automatic drain();
        while (address_q.size() != 0 || s_valid || outcome_q.size() != 0) @(posedge aclk);
        repeat (300) @(posedge aclk);
    endtask

    // Addresses clustered so that hits are frequent for the current geometry
    task automatic queue_random(int n);
        logic [31:0] pool [16];
        for (int i = 0; i < 16; i++) pool[i] = $urandom;
        for (int i = 0; i < n; i++) begin
            case ($urandom_range(0, 3))
                0: address_q.push_back($urandom);
                1: address_q.push_back(pool[$urandom_range(0, 15)] ^ $urandom_range(0, 15));
                default: address_q.push_back(32'(({$urandom_range(0, 3), 2'b00} << 28)
                                                 | $urandom_range(0, 2047)));
            endcase
        end
    endtask

    initial begin
        psel = 0; penable = 0; pwrite = 0; paddr = 0; pwdata = 0;
        s_valid = 0; s_address = 0; m_ready = 0;
        sender_hold = 0; quiet_run = 0; long_stall = 0; errors = 0; stuck = 0;
        geo_line = chmt_pkg::RST_LINE_SIZE_LOG2; geo_lines = chmt_pkg::RST_CACHE_LINES_LOG2;
        geo_ways = chmt_pkg::RST_SET_WAYS_LOG2;
        seen_total = 0;
        for (int i = 0; i < 5; i++) hit_tally[i] = 0;
        flush_caches();
        aresetn = 0;
        repeat (11) @(posedge aclk);
        aresetn <= 1;

        // Directed: address extremes, block zero on empty stores, repeats
        address_q = '{32'h0, 32'h0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h1, 32'h4,
                       32'h400, 32'h800, 32'h0, 32'hAAAA_AAAA, 32'h5555_5555, 32'h4};
        drain();

        // Receiver holds off long so the block backs up its input
        long_stall <= 800;
        queue_random(20);
        drain();

        // Geometry extremes, every register, then reset values
        apb_write(chmt_pkg::REG_LINE_SIZE_LOG2, 4'd15);
        apb_write(chmt_pkg::REG_CACHE_LINES_LOG2, 4'd0);
        apb_write(chmt_pkg::REG_SET_WAYS_LOG2, 4'd15);
        address_q = '{32'h0, 32'h1000, 32'h0, 32'hFFF, 32'h2000, 32'h1000};
        drain();
        apb_write(chmt_pkg::REG_LINE_SIZE_LOG2, 4'd0);
        apb_write(chmt_pkg::REG_CACHE_LINES_LOG2, 4'd15);
        apb_write(chmt_pkg::REG_SET_WAYS_LOG2, 4'd0);
        queue_random(200);
        drain();
        apb_write(chmt_pkg::REG_CACHE_LINES_LOG2, 4'd2);
        apb_write(chmt_pkg::REG_SET_WAYS_LOG2, 4'd1);
        apb_write(chmt_pkg::REG_LINE_SIZE_LOG2, 4'd12);
        queue_random(200);
        drain();

        // Sender pauses with addresses queued, then resumes
        sender_hold = 1;
        queue_random(5);
        repeat (50) @(posedge aclk);
        sender_hold = 0;
        drain();

        apb_write(chmt_pkg::REG_CACHE_LINES_LOG2, 4'd5);
        apb_write(chmt_pkg::REG_SET_WAYS_LOG2, 4'd8);
        apb_write(chmt_pkg::REG_LINE_SIZE_LOG2, 4'd3);
        queue_random(200);
        drain();
        apb_write(chmt_pkg::REG_LINE_SIZE_LOG2, chmt_pkg::RST_LINE_SIZE_LOG2);
        apb_write(chmt_pkg::REG_CACHE_LINES_LOG2, chmt_pkg::RST_CACHE_LINES_LOG2);
        apb_write(chmt_pkg::REG_SET_WAYS_LOG2, chmt_pkg::RST_SET_WAYS_LOG2);
        queue_random(250);
        drain();
        quiet_run = 1;
        queue_random(130);
        drain();

        if (errors == 0) $display("RESULT: OK");
        else $display("RESULT: ERROR");
        $finish;
    end
endmodule
